// ===== rtl/sm3cr_pkg.sv =====
package sm3cr_pkg;

  typedef logic [31:0] word_t;
  typedef logic [5:0]  round_t;

  localparam round_t LAST_ROUND = 6'd63;
  localparam round_t XOR_LAST_ROUND = 6'd15;

  localparam word_t T_LOW  = 32'h79CC4519;
  localparam word_t T_HIGH = 32'h7A879D8A;

  localparam word_t IV [8] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  function automatic word_t rotl32(input word_t x, input logic [4:0] n);
    logic [63:0] dbl;
    dbl = {x, x} << n;
    return dbl[63:32];
  endfunction

  function automatic word_t p0_perm(input word_t x);
    return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
  endfunction

endpackage

// ===== rtl/sm3_compression_round.sv =====
// One SM3 round per accepted transfer; a new transfer can be taken every cycle, except that the round 63 transfer
// is stalled while a result is still pending. The digest appears in the output register in the cycle after it.
// The round logic (one three-operand and two four-operand add chains and rotates) sits between the
// working registers and the chaining/output registers.
// Synchronous active-low reset: round counter 0, chaining value = SM3 IV,
// no result pending. Working registers are not reset; round 0 always loads them.
module sm3_compression_round (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_round_word,
  input  logic [31:0] in_round_word_mixed,
  input  logic        in_start_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word_0,
  output logic [31:0] out_digest_word_1,
  output logic [31:0] out_digest_word_2,
  output logic [31:0] out_digest_word_3,
  output logic [31:0] out_digest_word_4,
  output logic [31:0] out_digest_word_5,
  output logic [31:0] out_digest_word_6,
  output logic [31:0] out_digest_word_7
);

  sm3cr_pkg::word_t  work_r   [8];
  sm3cr_pkg::word_t  work_nxt [8];
  sm3cr_pkg::word_t  cv_r     [8];
  sm3cr_pkg::word_t  cv_nxt   [8];
  sm3cr_pkg::word_t  dig_r    [8];
  sm3cr_pkg::word_t  src      [8];
  sm3cr_pkg::word_t  cv_src   [8];
  sm3cr_pkg::round_t round_r;
  sm3cr_pkg::round_t round_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;

  logic              in_acc;
  logic              first_rnd;
  logic              last_rnd;
  logic              xor_rnd;
  sm3cr_pkg::word_t  tj, a12, ss1, ss2, ffv, ggv, tt1, tt2;

  assign first_rnd = (round_r == '0);
  assign last_rnd  = (round_r == sm3cr_pkg::LAST_ROUND);
  assign xor_rnd   = (round_r <= sm3cr_pkg::XOR_LAST_ROUND);

  // only the block-ending transfer needs the output register free
  assign in_stall = out_valid_r & out_stall & last_rnd;
  assign in_acc   = in_valid & ~in_stall;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      cv_src[k] = (first_rnd && in_start_message) ? sm3cr_pkg::IV[k] : cv_r[k];
      src[k]    = first_rnd ? cv_src[k] : work_r[k];
    end

    tj  = sm3cr_pkg::rotl32(xor_rnd ? sm3cr_pkg::T_LOW : sm3cr_pkg::T_HIGH, round_r[4:0]);
    a12 = sm3cr_pkg::rotl32(src[0], 5'd12);
    ss1 = sm3cr_pkg::rotl32(a12 + src[4] + tj, 5'd7);
    ss2 = ss1 ^ a12;

    if (xor_rnd) begin
      ffv = src[0] ^ src[1] ^ src[2];
      ggv = src[4] ^ src[5] ^ src[6];
    end else begin
      ffv = (src[0] & src[1]) | (src[0] & src[2]) | (src[1] & src[2]);
      ggv = (src[4] & src[5]) | (~src[4] & src[6]);
    end

    tt1 = ffv + src[3] + ss2 + in_round_word_mixed;
    tt2 = ggv + src[7] + ss1 + in_round_word;

    work_nxt[0] = tt1;
    work_nxt[1] = src[0];
    work_nxt[2] = sm3cr_pkg::rotl32(src[1], 5'd9);
    work_nxt[3] = src[2];
    work_nxt[4] = sm3cr_pkg::p0_perm(tt2);
    work_nxt[5] = src[4];
    work_nxt[6] = sm3cr_pkg::rotl32(src[5], 5'd19);
    work_nxt[7] = src[6];

    for (int k = 0; k < 8; k++) begin
      cv_nxt[k] = last_rnd ? (cv_src[k] ^ work_nxt[k]) : cv_src[k];
    end

    round_nxt     = in_acc ? round_r + 6'd1 : round_r;
    out_valid_nxt = out_valid_r & out_stall;
    if (in_acc && last_rnd) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_r     <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 8; k++) begin
        cv_r[k] <= sm3cr_pkg::IV[k];
      end
    end else begin
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        for (int k = 0; k < 8; k++) begin
          cv_r[k] <= cv_nxt[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int k = 0; k < 8; k++) begin
        work_r[k] <= work_nxt[k];
      end
      if (last_rnd) begin
        for (int k = 0; k < 8; k++) begin
          dig_r[k] <= cv_nxt[k];
        end
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_digest_word_0 = dig_r[0];
  assign out_digest_word_1 = dig_r[1];
  assign out_digest_word_2 = dig_r[2];
  assign out_digest_word_3 = dig_r[3];
  assign out_digest_word_4 = dig_r[4];
  assign out_digest_word_5 = dig_r[5];
  assign out_digest_word_6 = dig_r[6];
  assign out_digest_word_7 = dig_r[7];

`ifndef ASSERT_OFF
  a_rose_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_acc && last_rnd))
    else $error("result raised without a round 63 transfer");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall && last_rnd))
    else $error("input stalled without a pending result");

  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && last_rnd) |=> (round_r == '0 && out_valid_r))
    else $error("round counter did not wrap with a result");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !(in_acc && last_rnd)) |=> !out_valid_r)
    else $error("result repeated after transfer");
`endif

endmodule

// ===== sim/tb_sm3_compression_round.sv =====
module tb_sm3_compression_round;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT           = 300000;
  localparam int NUM_RAND_BLOCKS = 21;
  localparam int REPORT_MAX      = 10;
  localparam int DRAIN_CYCLES    = 16;
  localparam int MAX_GAP         = 8;

  typedef logic [7:0][31:0] digest_t;

  typedef struct {
    sm3cr_pkg::word_t w;
    sm3cr_pkg::word_t wm;
    logic             start0;
    logic             start_rest;
  } block_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_round_word = '0;
  logic [31:0] in_round_word_mixed = '0;
  logic        in_start_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_digest_word_0;
  logic [31:0] out_digest_word_1;
  logic [31:0] out_digest_word_2;
  logic [31:0] out_digest_word_3;
  logic [31:0] out_digest_word_4;
  logic [31:0] out_digest_word_5;
  logic [31:0] out_digest_word_6;
  logic [31:0] out_digest_word_7;

  sm3cr_pkg::word_t  chain_val [8];
  sm3cr_pkg::word_t  work_reg [8];
  sm3cr_pkg::round_t round_cnt;
  digest_t           digest_q [$];
  int                errors = 0;
  int                cycle_cnt = 0;
  int                hold = 0;
  bit                calm = 1'b0;

  block_row_t dir_rows [6] = '{
    '{32'h00000000, 32'h00000000, 1'b0, 1'b0},  // reset IV, no start
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 1'b1},  // chained; late start ignored
    '{32'hAAAAAAAA, 32'h55555555, 1'b1, 1'b1},
    '{32'h55555555, 32'hAAAAAAAA, 1'b0, 1'b0},
    '{32'hFFFFFFFF, 32'h00000000, 1'b1, 1'b0},
    '{32'h00000000, 32'hFFFFFFFF, 1'b1, 1'b1}
  };

  sm3_compression_round u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_round_word       (in_round_word),
    .in_round_word_mixed (in_round_word_mixed),
    .in_start_message    (in_start_message),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_digest_word_0   (out_digest_word_0),
    .out_digest_word_1   (out_digest_word_1),
    .out_digest_word_2   (out_digest_word_2),
    .out_digest_word_3   (out_digest_word_3),
    .out_digest_word_4   (out_digest_word_4),
    .out_digest_word_5   (out_digest_word_5),
    .out_digest_word_6   (out_digest_word_6),
    .out_digest_word_7   (out_digest_word_7)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  function automatic sm3cr_pkg::word_t rol(input sm3cr_pkg::word_t x, input int unsigned n);
    int unsigned k;
    k = n & 31;
    return (x << k) | (x >> (32 - k));
  endfunction

  // one round on the working registers; returns 1 with the new chaining value after round 63
  function automatic bit compress_round(input sm3cr_pkg::word_t w, input sm3cr_pkg::word_t wm,
                                        input logic start, output digest_t dig);
    sm3cr_pkg::word_t a, b, c, d, e, f, g, h;
    sm3cr_pkg::word_t a12, tj, ss1, ss2, ffv, ggv, tt1, tt2;
    int k;
    if (round_cnt == 0) begin
      for (k = 0; k < 8; k++) begin
        if (start) chain_val[k] = sm3cr_pkg::IV[k];
        work_reg[k] = chain_val[k];
      end
    end
    a = work_reg[0]; b = work_reg[1]; c = work_reg[2]; d = work_reg[3];
    e = work_reg[4]; f = work_reg[5]; g = work_reg[6]; h = work_reg[7];
    tj  = rol((round_cnt <= sm3cr_pkg::XOR_LAST_ROUND) ? sm3cr_pkg::T_LOW : sm3cr_pkg::T_HIGH,
              round_cnt);
    a12 = rol(a, 12);
    ss1 = rol(a12 + e + tj, 7);
    ss2 = ss1 ^ a12;
    if (round_cnt <= sm3cr_pkg::XOR_LAST_ROUND) begin
      ffv = a ^ b ^ c;
      ggv = e ^ f ^ g;
    end else begin
      ffv = (a & b) | (a & c) | (b & c);
      ggv = (e & f) | (~e & g);
    end
    tt1 = ffv + d + ss2 + wm;
    tt2 = ggv + h + ss1 + w;
    work_reg[3] = c;
    work_reg[2] = rol(b, 9);
    work_reg[1] = a;
    work_reg[0] = tt1;
    work_reg[7] = g;
    work_reg[6] = rol(f, 19);
    work_reg[5] = e;
    work_reg[4] = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
    if (round_cnt != sm3cr_pkg::LAST_ROUND) begin
      round_cnt = round_cnt + 1'b1;
      return 1'b0;
    end
    round_cnt = '0;
    for (k = 0; k < 8; k++) begin
      chain_val[k] = chain_val[k] ^ work_reg[k];
      dig[k] = chain_val[k];
    end
    return 1'b1;
  endfunction

  task automatic send_round(input sm3cr_pkg::word_t w, input sm3cr_pkg::word_t wm,
                            input logic start);
    int gap;
    digest_t dig;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_round_word       <= w;
    in_round_word_mixed <= wm;
    in_start_message    <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (compress_round(w, wm, start, dig)) digest_q.push_back(dig);
  endtask

  // hold stall on each digest until a randomly drawn countdown runs out; drawn at reset and at each digest transfer
  always @(posedge clk) begin
    int n;
    if (!rst_n || (out_valid && !out_stall)) begin
      n = calm ? 0 : $urandom_range(0, MAX_GAP);
      hold      <= n;
      out_stall <= (n != 0);
    end else if (out_valid && out_stall) begin
      if (hold <= 1) begin
        hold      <= 0;
        out_stall <= 1'b0;
      end else begin
        hold <= hold - 1;
      end
    end
  end

  always @(posedge clk) begin
    digest_t got, want;
    int k;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_digest_word_7, out_digest_word_6, out_digest_word_5, out_digest_word_4,
             out_digest_word_3, out_digest_word_2, out_digest_word_1, out_digest_word_0};
      if (digest_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX) $display("unexpected digest transfer: %h", got);
      end else begin
        want = digest_q.pop_front();
        for (k = 0; k < 8; k++) begin
          if (got[k] !== want[k]) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display("digest_word_%0d: expected %h, got %h", k, want[k], got[k]);
          end
        end
      end
    end
  end

  initial begin
    wait (cycle_cnt >= LIMIT);
    $display("FAIL sm3_compression_round");
    $finish;
  end

  initial begin
    int kind;
    sm3cr_pkg::word_t w, wm;
    for (int k = 0; k < 8; k++) chain_val[k] = sm3cr_pkg::IV[k];
    for (int k = 0; k < 8; k++) work_reg[k] = '0;
    round_cnt = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      calm = (i % 2 == 0);
      for (int r = 0; r < 64; r++)
        send_round(dir_rows[i].w, dir_rows[i].wm,
                   (r == 0) ? dir_rows[i].start0 : dir_rows[i].start_rest);
    end

    for (int b = 0; b < NUM_RAND_BLOCKS; b++) begin
      calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 7);
      for (int r = 0; r < 64; r++) begin
        case (kind)
          0: begin
            w  = '0;
            wm = '0;
          end
          1: begin
            w  = '1;
            wm = '1;
          end
          2: begin
            w  = $urandom;
            wm = ($urandom_range(0, 1) == 1) ? '1 : '0;
          end
          default: begin
            w  = $urandom;
            wm = $urandom;
          end
        endcase
        send_round(w, wm, 1'($urandom_range(0, 1)));
      end
    end
    in_valid <= 1'b0;

    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("PASS sm3_compression_round");
    end else begin
      $display("FAIL sm3_compression_round");
    end
    $finish;
  end

endmodule
